FILE: hw/rtl/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types and constants for the positional array list unit.
// ----------------------------------------------------------------------------
package pal_pkg;

    localparam int DEPTH       = 16;
    localparam int ENTRY_WIDTH = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);

    localparam int OP_W        = 3;
    localparam int POS_W       = 5;
    localparam int COUNT_OUT_W = 5;
    localparam int WORD_OUT_W  = 32;

    typedef logic [ENTRY_WIDTH-1:0] entry_t;
    typedef logic [IDX_W-1:0]       idx_t;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_RM_LAST   = 3'd3,
        OP_RM_FIRST  = 3'd4,
        OP_RM_AT     = 3'd5,
        OP_READ_AT   = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ACT_HOLD,
        ACT_INS,
        ACT_DEL
    } act_t;

    typedef struct packed {
        act_t   act;
        idx_t   idx;
        entry_t word;
    } cell_cmd_t;

endpackage

FILE: hw/rtl/pal_cell.sv
// ----------------------------------------------------------------------------
// pal_cell
// One list slot: holds an entry, takes its lower neighbour on insert and its
// upper neighbour on remove, and offers its entry when the index matches.
// ----------------------------------------------------------------------------
module pal_cell (
    input  logic               aclk,
    input  pal_pkg::cell_cmd_t cmd,
    input  pal_pkg::idx_t      cell_idx,
    input  pal_pkg::entry_t    below_value,
    input  pal_pkg::entry_t    above_value,
    output pal_pkg::entry_t    value,
    output pal_pkg::entry_t    rd_data
);
    import pal_pkg::*;

    entry_t value_reg;
    entry_t value_next;

    always_comb begin
        value_next = value_reg;
        case (cmd.act)
            ACT_INS: begin
                if (cell_idx == cmd.idx) begin
                    value_next = cmd.word;
                end else if (cell_idx > cmd.idx) begin
                    value_next = below_value;
                end
            end
            ACT_DEL: begin
                if (cell_idx >= cmd.idx) begin
                    value_next = above_value;
                end
            end
            default: begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value   = value_reg;
    assign rd_data = (cell_idx == cmd.idx) ? value_reg : '0;

endmodule

FILE: hw/rtl/positional_array_list_unit.sv
// ----------------------------------------------------------------------------
// positional_array_list_unit
// Ordered list of up to DEPTH words with insert, remove and read by position.
// ----------------------------------------------------------------------------
// The list is a row of DEPTH cells, one entry each; an insert or remove moves
// every affected entry by one place in the same cycle, and a new command is
// accepted every cycle while the result register is empty or being taken.
// Each command gives exactly one result:
// success flag, count afterwards, read word (zero unless a successful read),
// and empty/full flags. Rejected commands leave the list unchanged.
module positional_array_list_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [pal_pkg::OP_W-1:0]        s_op,
    input  logic [pal_pkg::POS_W-1:0]       s_position,
    input  logic [pal_pkg::WORD_OUT_W-1:0]  s_entry_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_ok,
    output logic [pal_pkg::COUNT_OUT_W-1:0] m_count,
    output logic [pal_pkg::WORD_OUT_W-1:0]  m_read_value,
    output logic                            m_is_empty,
    output logic                            m_is_full
);
    import pal_pkg::*;

    logic                   accept;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   full;
    logic                   pos_ok;
    logic [POS_W-1:0]       pos_m1;
    idx_t                   pos_idx;
    logic                   ok_c;
    logic                   rd_sel;
    entry_t                 word_c;
    entry_t                 rd_or;
    cell_cmd_t              cmd;

    entry_t                 cell_value [DEPTH];
    entry_t                 cell_rd    [DEPTH];

    logic                   m_valid_reg;
    logic                   m_ok_reg;
    logic [CNT_W-1:0]       m_count_reg;
    logic [WORD_OUT_W-1:0]  m_read_value_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign word_c  = ENTRY_WIDTH'(s_entry_value);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign pos_ok  = (s_position != '0) && (int'(s_position) <= int'(count_reg));
    assign pos_m1  = s_position - POS_W'(1);
    assign pos_idx = pos_m1[IDX_W-1:0];

    always_comb begin
        cmd.act    = ACT_HOLD;
        cmd.idx    = pos_idx;
        cmd.word   = word_c;
        ok_c       = 1'b0;
        rd_sel     = 1'b0;
        count_next = count_reg;
        case (op_t'(s_op))
            OP_INS_FRONT: begin
                if (!full) begin
                    cmd.act    = ACT_INS;
                    cmd.idx    = '0;
                    ok_c       = 1'b1;
                    count_next = CNT_W'(count_reg + 1'b1);
                end
            end
            OP_INS_BACK: begin
                if (!full) begin
                    cmd.act    = ACT_INS;
                    cmd.idx    = count_reg[IDX_W-1:0];
                    ok_c       = 1'b1;
                    count_next = CNT_W'(count_reg + 1'b1);
                end
            end
            OP_INS_AT: begin
                if (!full && pos_ok) begin
                    cmd.act    = ACT_INS;
                    ok_c       = 1'b1;
                    count_next = CNT_W'(count_reg + 1'b1);
                end
            end
            OP_RM_LAST: begin
                if (count_reg != '0) begin
                    ok_c       = 1'b1;
                    count_next = CNT_W'(count_reg - 1'b1);
                end
            end
            OP_RM_FIRST: begin
                if (count_reg != '0) begin
                    cmd.act    = ACT_DEL;
                    cmd.idx    = '0;
                    ok_c       = 1'b1;
                    count_next = CNT_W'(count_reg - 1'b1);
                end
            end
            OP_RM_AT: begin
                if (pos_ok) begin
                    cmd.act    = ACT_DEL;
                    ok_c       = 1'b1;
                    count_next = CNT_W'(count_reg - 1'b1);
                end
            end
            OP_READ_AT: begin
                if (pos_ok) begin
                    ok_c   = 1'b1;
                    rd_sel = 1'b1;
                end
            end
            default: begin
                ok_c = 1'b0;
            end
        endcase
        // hold the cells unless a transfer is taken
        if (!accept) begin
            cmd.act = ACT_HOLD;
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        entry_t below;
        entry_t above;
        if (i == 0) begin : g_first
            assign below = '0;
        end else begin : g_below
            assign below = cell_value[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign above = '0;
        end else begin : g_above
            assign above = cell_value[i+1];
        end
        pal_cell u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .cell_idx    (IDX_W'(i)),
            .below_value (below),
            .above_value (above),
            .value       (cell_value[i]),
            .rd_data     (cell_rd[i])
        );
    end

    always_comb begin
        rd_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rd_or = rd_or | cell_rd[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_ok_reg         <= ok_c;
            m_count_reg      <= count_next;
            m_read_value_reg <= rd_sel ? WORD_OUT_W'(rd_or) : '0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_ok         = m_ok_reg;
    assign m_count      = COUNT_OUT_W'(m_count_reg);
    assign m_read_value = m_read_value_reg;
    assign m_is_empty   = (m_count_reg == '0);
    assign m_is_full    = (m_count_reg == CNT_W'(DEPTH));

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(count_reg) <= DEPTH)
        else $error("fill count above depth");

    a_reject_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !ok_c |=> count_reg == $past(count_reg))
        else $error("rejected command changed the count");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && ok_c && cmd.act == ACT_INS
        |=> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("insert did not grow the count");

    a_result_count: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid && m_count_reg == count_reg)
        else $error("result count differs from fill count");

    a_reject_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ok |-> m_read_value == '0)
        else $error("rejected command returned data");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the positional array list unit. A short table of
// commands covers empty and full lists, bad positions and the unused op
// code. Biased random commands then fill and drain the list repeatedly.
// The list is tracked here and every result is compared in order with the
// expected one, under several patterns of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import pal_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED    = 3'd7;
    localparam int              CYCLE_LIMIT  = 500_000;
    localparam int              PHASE_ITEMS  = 470;
    localparam int              DRAIN_CYCLES = 16;
    localparam int              MAX_GAP      = 40;

    typedef struct packed {
        logic                   ok;
        logic [COUNT_OUT_W-1:0] count;
        logic [WORD_OUT_W-1:0]  read_value;
        logic                   is_empty;
        logic                   is_full;
    } list_result_t;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        entry_t           word;
        int               reps;
        bit               typed;
        list_result_t     want;
    } cmd_row_t;

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_valid       = 1'b0;
    logic                   s_ready;
    logic [OP_W-1:0]        s_op          = '0;
    logic [POS_W-1:0]       s_position    = '0;
    logic [WORD_OUT_W-1:0]  s_entry_value = '0;
    logic                   m_valid;
    logic                   m_ready       = 1'b0;
    logic                   m_ok;
    logic [COUNT_OUT_W-1:0] m_count;
    logic [WORD_OUT_W-1:0]  m_read_value;
    logic                   m_is_empty;
    logic                   m_is_full;

    entry_t       list_words [DEPTH];
    int           list_fill      = 0;
    list_result_t pending_results[$];
    int           mismatch_count = 0;
    int           cycle_count    = 0;
    int           idle_pct       = 0;
    int           stall_pct      = 0;

    positional_array_list_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_position    (s_position),
        .s_entry_value (s_entry_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ok          (m_ok),
        .m_count       (m_count),
        .m_read_value  (m_read_value),
        .m_is_empty    (m_is_empty),
        .m_is_full     (m_is_full)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic list_result_t apply_list_cmd(logic [OP_W-1:0] op,
                                                    logic [POS_W-1:0] pos,
                                                    entry_t word);
        list_result_t res;
        bit           full;
        bit           pos_ok;
        int           p;
        p      = pos;
        full   = list_fill >= DEPTH;
        pos_ok = p >= 1 && p <= list_fill;
        res    = '0;
        case (op)
            OP_INS_FRONT: if (!full) begin
                for (int i = list_fill; i > 0; i--) list_words[i] = list_words[i-1];
                list_words[0] = word;
                list_fill++;
                res.ok = 1'b1;
            end
            OP_INS_BACK: if (!full) begin
                list_words[list_fill] = word;
                list_fill++;
                res.ok = 1'b1;
            end
            OP_INS_AT: if (!full && pos_ok) begin
                for (int i = list_fill; i > p - 1; i--) list_words[i] = list_words[i-1];
                list_words[p-1] = word;
                list_fill++;
                res.ok = 1'b1;
            end
            OP_RM_LAST: if (list_fill > 0) begin
                list_fill--;
                res.ok = 1'b1;
            end
            OP_RM_FIRST: if (list_fill > 0) begin
                for (int i = 0; i + 1 < list_fill; i++) list_words[i] = list_words[i+1];
                list_fill--;
                res.ok = 1'b1;
            end
            OP_RM_AT: if (pos_ok) begin
                for (int i = p - 1; i + 1 < list_fill; i++) list_words[i] = list_words[i+1];
                list_fill--;
                res.ok = 1'b1;
            end
            OP_READ_AT: if (pos_ok) begin
                res.read_value = list_words[p-1];
                res.ok         = 1'b1;
            end
            default: ;
        endcase
        res.count    = COUNT_OUT_W'(list_fill);
        res.is_empty = list_fill == 0;
        res.is_full  = list_fill >= DEPTH;
        return res;
    endfunction

    function automatic cmd_row_t mk_row(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                        entry_t word, int reps, bit typed,
                                        logic ok, int cnt, entry_t rd);
        cmd_row_t row;
        row.op                  = op;
        row.pos                 = pos;
        row.word                = word;
        row.reps                = reps;
        row.typed               = typed;
        row.want.ok             = ok;
        row.want.count          = COUNT_OUT_W'(cnt);
        row.want.read_value     = rd;
        row.want.is_empty       = cnt == 0;
        row.want.is_full        = cnt == DEPTH;
        return row;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, field, want, got);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : result_check
        list_result_t got;
        list_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got.ok         = m_ok;
            got.count      = m_count;
            got.read_value = m_read_value;
            got.is_empty   = m_is_empty;
            got.is_full    = m_is_full;
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected result transfer, expected none, actual %h",
                         $time, got);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.ok !== want.ok) report_mismatch("ok", want.ok, got.ok);
                if (got.count !== want.count)
                    report_mismatch("count", want.count, got.count);
                if (got.read_value !== want.read_value)
                    report_mismatch("read_value", want.read_value, got.read_value);
                if (got.is_empty !== want.is_empty)
                    report_mismatch("is_empty", want.is_empty, got.is_empty);
                if (got.is_full !== want.is_full)
                    report_mismatch("is_full", want.is_full, got.is_full);
            end
        end
    end

    task automatic send_cmd(logic [OP_W-1:0] op, logic [POS_W-1:0] pos, entry_t word,
                            bit typed, list_result_t want);
        list_result_t predicted;
        int           gap;
        s_valid       <= 1'b1;
        s_op          <= op;
        s_position    <= pos;
        s_entry_value <= word;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_list_cmd(op, pos, word);
        pending_results.push_back(typed ? want : predicted);
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() > 0);
    endtask

    task automatic run_phase(int idle, int stall, int pause_at);
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        entry_t           word;
        int               pick;
        bit               growing;
        idle_pct  = idle;
        stall_pct = stall;
        growing   = 1'b1;
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (k == pause_at) hold_until_drained();
            if (list_fill == DEPTH && $urandom_range(99) < 30) growing = 1'b0;
            else if (list_fill == 0) growing = 1'b1;
            else if ($urandom_range(99) < 2) growing = !growing;
            pick = $urandom_range(99);
            if (pick < 3) op = OP_UNUSED;
            else if (pick < 20) op = OP_READ_AT;
            else if ((pick < 72) == growing) op = OP_W'($urandom_range(OP_INS_AT, OP_INS_FRONT));
            else op = OP_W'($urandom_range(OP_RM_AT, OP_RM_LAST));
            if (list_fill > 0 && $urandom_range(99) < 85)
                pos = POS_W'($urandom_range(list_fill, 1));
            else
                pos = POS_W'($urandom_range(31));
            case ($urandom_range(9))
                0:       word = '0;
                1:       word = '1;
                default: word = $urandom();
            endcase
            send_cmd(op, pos, word, 1'b0, '0);
        end
    endtask

    initial begin
        cmd_row_t directed_rows [25];
        int       wait_cycles;
        directed_rows = '{
            mk_row(OP_RM_LAST,   0,  32'h0,         1,  1, 0, 0,  32'h0),
            mk_row(OP_RM_FIRST,  0,  32'h0,         1,  1, 0, 0,  32'h0),
            mk_row(OP_RM_AT,     1,  32'h0,         1,  1, 0, 0,  32'h0),
            mk_row(OP_READ_AT,   0,  32'h0,         1,  1, 0, 0,  32'h0),
            mk_row(OP_INS_AT,    1,  32'h1234_5678, 1,  1, 0, 0,  32'h0),
            mk_row(OP_INS_BACK,  0,  32'hFFFF_FFFF, 1,  1, 1, 1,  32'h0),
            mk_row(OP_INS_FRONT, 31, 32'h0,         1,  1, 1, 2,  32'h0),
            mk_row(OP_READ_AT,   1,  32'h0,         1,  1, 1, 2,  32'h0),
            mk_row(OP_READ_AT,   2,  32'h0,         1,  1, 1, 2,  32'hFFFF_FFFF),
            mk_row(OP_READ_AT,   0,  32'h0,         1,  1, 0, 2,  32'h0),
            mk_row(OP_READ_AT,   3,  32'h0,         1,  1, 0, 2,  32'h0),
            mk_row(OP_INS_AT,    2,  32'hA5A5_5A5A, 1,  0, 0, 0,  32'h0),
            mk_row(OP_INS_AT,    0,  32'h5A5A_A5A5, 1,  1, 0, 3,  32'h0),
            mk_row(OP_UNUSED,    1,  32'hFFFF_FFFF, 1,  1, 0, 3,  32'h0),
            mk_row(OP_RM_AT,     31, 32'h0,         1,  1, 0, 3,  32'h0),
            mk_row(OP_READ_AT,   2,  32'h0,         1,  0, 0, 0,  32'h0),
            mk_row(OP_INS_BACK,  0,  32'h1000_0000, 13, 0, 0, 0,  32'h0),
            mk_row(OP_INS_FRONT, 0,  32'hDEAD_BEEF, 1,  1, 0, 16, 32'h0),
            mk_row(OP_INS_BACK,  0,  32'hDEAD_BEEF, 1,  1, 0, 16, 32'h0),
            mk_row(OP_INS_AT,    16, 32'hDEAD_BEEF, 1,  1, 0, 16, 32'h0),
            mk_row(OP_READ_AT,   16, 32'h0,         1,  0, 0, 0,  32'h0),
            mk_row(OP_RM_AT,     16, 32'h0,         1,  0, 0, 0,  32'h0),
            mk_row(OP_INS_AT,    15, 32'h8000_0001, 1,  0, 0, 0,  32'h0),
            mk_row(OP_RM_FIRST,  0,  32'h0,         15, 0, 0, 0,  32'h0),
            mk_row(OP_RM_LAST,   0,  32'h0,         1,  1, 1, 0,  32'h0)
        };

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[r])
            for (int n = 0; n < directed_rows[r].reps; n++)
                send_cmd(directed_rows[r].op, directed_rows[r].pos,
                         directed_rows[r].word + entry_t'(n),
                         directed_rows[r].typed, directed_rows[r].want);
        hold_until_drained();

        run_phase(0,  0,  200);
        run_phase(68, 0,  -1);
        run_phase(0,  68, -1);
        run_phase(15, 15, -1);

        s_valid <= 1'b0;
        wait_cycles = 0;
        while (pending_results.size() > 0 && wait_cycles < 5000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        if (pending_results.size() > 0) begin
            $display("%0t ns: results missing, expected %0d more, actual 0",
                     $time, pending_results.size());
            mismatch_count += pending_results.size();
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
